// File: rtl/utf8_to_wide_decoder_macros.svh
// Assertion macros for the UTF-8 to wide decoder
`ifndef UTF8_TO_WIDE_DECODER_MACROS_SVH
`define UTF8_TO_WIDE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define UTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8_to_wide_decoder: assertion failed");
// Next-cycle implication, checked out of reset
`define UTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8_to_wide_decoder: assertion failed");
`else
`define UTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/utw_pkg.sv
// Types and constants shared by the UTF-8 to wide decoder modules
package utw_pkg;

  // One result item as it leaves the block
  typedef struct packed {
    logic [20:0] code_unit;
    logic        is_replacement;
    logic        run_last;
    logic        text_end;
  } utw_result_t;

  // Running sequence state
  typedef struct packed {
    logic [20:0] partial_value;
    logic [1:0]  bytes_remaining;
    logic [1:0]  sequence_extra;
  } utw_state_t;

  // Results produced by one byte: count and up to two units
  typedef struct packed {
    logic [1:0]  num;
    utw_result_t unit0;
    utw_result_t unit1;
  } utw_emit_t;

  // Output forms
  localparam logic FORM_UTF16 = 1'b0;
  localparam logic FORM_UTF32 = 1'b1;

  // Code point constants
  localparam logic [20:0] REPL_CHAR     = 21'h00FFFD;
  localparam logic [20:0] MAX_CP        = 21'h10FFFF;
  localparam logic [20:0] SURR_LO       = 21'h00D800;
  localparam logic [20:0] SURR_HI       = 21'h00DFFF;
  localparam logic [20:0] LOW_SURR_BASE = 21'h00DC00;
  localparam logic [20:0] TEN_BIT_MASK  = 21'h0003FF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] MIN_EXTRA2    = 21'h000800;
  localparam logic [20:0] MIN_EXTRA1    = 21'h000080;

  // Continuation counts
  localparam logic [1:0] EXTRA_NONE  = 2'd0;
  localparam logic [1:0] EXTRA_ONE   = 2'd1;
  localparam logic [1:0] EXTRA_TWO   = 2'd2;
  localparam logic [1:0] EXTRA_THREE = 2'd3;

endpackage

// File: rtl/utf8_to_wide_decoder.sv
// Streaming UTF-8 to UTF-16 / UTF-32 decoder, top level
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | in_valid / in_stall        | in_byte[7:0], in_last
//  result   | out_valid / out_stall      | out_code_unit[20:0], out_is_replacement,
//           |                            | out_run_last, out_text_end
//  config   | cfg_we                     | cfg_wdata (output form)
//
// One byte is taken per cycle while in_stall is low. A byte is registered in the input
// stage, is decoded there against the sequence state and lands in the result queue,
// whose head drives the result port; the byte waits in the stage while in_stall is high.
// A byte giving two results (surrogate pair or broken sequence) puts both in the queue,
// and the result port delivers them one per transfer. Reset is synchronous and
// empties the stage and the queue. in_stall rises only when the queue lacks space for
// two results and holds the input stage.
module utf8_to_wide_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_unit,
  output logic        out_is_replacement,
  output logic        out_run_last,
  output logic        out_text_end,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import utw_pkg::*;

  `include "utf8_to_wide_decoder_macros.svh"

  localparam int CNT_W = $clog2(FIFO_DEPTH+1);

  logic             form_r;
  logic             stg_vld_r;
  logic             stg_vld_nxt;
  logic [7:0]       stg_byte_r;
  logic             stg_last_r;
  utw_state_t       st_r;
  utw_state_t       st_nxt;
  utw_emit_t        emit;
  utw_result_t      head;
  logic             room;
  logic [CNT_W-1:0] q_cnt;
  logic [CNT_W:0]   q_sum;
  logic             in_xfer;
  logic             dec_adv;
  logic [1:0]       push_num;

  // Input stage handshake
  assign dec_adv     = stg_vld_r && room;
  assign in_stall    = stg_vld_r && !room;
  assign in_xfer     = in_valid && !in_stall;
  assign stg_vld_nxt = in_xfer || (stg_vld_r && !room);
  assign push_num    = dec_adv ? emit.num : 2'd0;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r    <= FORM_UTF16;
      stg_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (cfg_we) begin
        form_r <= cfg_wdata;
      end
      stg_vld_r <= stg_vld_nxt;
      if (dec_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_byte_r <= in_byte;
      stg_last_r <= in_last;
    end
  end

  utw_decode u_decode (
    .form    (form_r),
    .byte_in (stg_byte_r),
    .last_in (stg_last_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .emit    (emit)
  );

  utw_out_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push0     (emit.unit0),
    .push1     (emit.unit1),
    .room      (room),
    .count     (q_cnt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_code_unit      = head.code_unit;
  assign out_is_replacement = head.is_replacement;
  assign out_run_last       = head.run_last;
  assign out_text_end       = head.text_end;

  // Checks
  assign q_sum = {1'b0, q_cnt} + (CNT_W+1)'(emit.num);

  `UTW_ASSERT_IMP(a_no_overflow, clk, rst_n, dec_adv, q_sum <= (CNT_W+1)'(FIFO_DEPTH))
  `UTW_ASSERT_NXT(a_closed_at_end, clk, rst_n, dec_adv && stg_last_r, st_r.bytes_remaining == EXTRA_NONE)
  `UTW_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, stg_vld_r && !dec_adv)

endmodule

// File: rtl/utw_decode.sv
// Combinational byte decode: running state and one byte to results and next state
module utw_decode (
  input  logic              form,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  input  utw_pkg::utw_state_t st,
  output utw_pkg::utw_state_t st_nxt,
  output utw_pkg::utw_emit_t  emit
);
  import utw_pkg::*;

  // Start-of-sequence decode
  logic        sb_vld;
  logic [20:0] sb_cp;
  logic        sb_rep;
  logic        sb_open;
  logic [20:0] sb_val;
  logic [1:0]  sb_extra;

  // First and second code point emissions
  logic        e0_vld;
  logic [20:0] e0_cp;
  logic        e0_rep;
  logic        e1_vld;
  logic [20:0] e1_cp;
  logic        e1_rep;

  logic        cont;
  logic [1:0]  rem_dec;
  logic [20:0] acc;
  logic [20:0] min_cp;
  logic        bad;
  logic        pair;
  logic [20:0] supp_off;
  utw_result_t u0;
  utw_result_t u1;
  logic [1:0]  num;

  assign cont = (byte_in[7:6] == 2'b10);

  // Lead byte classification, independent of the running state
  always_comb begin
    sb_vld   = 1'b0;
    sb_cp    = REPL_CHAR;
    sb_rep   = 1'b0;
    sb_open  = 1'b0;
    sb_val   = '0;
    sb_extra = EXTRA_NONE;
    if (!byte_in[7]) begin
      sb_vld = 1'b1;
      sb_cp  = {13'd0, byte_in};
    end else if (byte_in[7:5] == 3'b110) begin
      sb_val   = {16'd0, byte_in[4:0]};
      sb_extra = EXTRA_ONE;
    end else if (byte_in[7:4] == 4'b1110) begin
      sb_val   = {17'd0, byte_in[3:0]};
      sb_extra = EXTRA_TWO;
    end else if (byte_in[7:3] == 5'b11110) begin
      sb_val   = {18'd0, byte_in[2:0]};
      sb_extra = EXTRA_THREE;
    end else begin
      sb_vld = 1'b1;
      sb_rep = 1'b1;
    end
    // a lead byte as the final byte is a truncated sequence
    if (sb_extra != EXTRA_NONE) begin
      if (last_in) begin
        sb_vld = 1'b1;
        sb_rep = 1'b1;
      end else begin
        sb_open = 1'b1;
      end
    end
  end

  // Lower bound of a non-overlong value for the open sequence
  always_comb begin
    case (st.sequence_extra)
      EXTRA_ONE:   min_cp = MIN_EXTRA1;
      EXTRA_TWO:   min_cp = MIN_EXTRA2;
      EXTRA_THREE: min_cp = SUPP_BASE;
      default:     min_cp = '0;
    endcase
  end

  assign rem_dec = st.bytes_remaining - 2'd1;
  assign acc     = {st.partial_value[14:0], byte_in[5:0]};
  assign bad     = (acc < min_cp) || (acc > MAX_CP) || ((acc >= SURR_LO) && (acc <= SURR_HI));

  // Sequence tracking and code point emissions
  always_comb begin
    st_nxt = st;
    e0_vld = 1'b0;
    e0_cp  = REPL_CHAR;
    e0_rep = 1'b1;
    e1_vld = 1'b0;
    e1_cp  = sb_cp;
    e1_rep = sb_rep;
    if (st.bytes_remaining != EXTRA_NONE) begin
      if (cont) begin
        if (rem_dec == EXTRA_NONE) begin
          // sequence complete
          e0_vld = 1'b1;
          e0_cp  = bad ? REPL_CHAR : acc;
          e0_rep = bad;
          st_nxt = '0;
        end else if (last_in) begin
          e0_vld = 1'b1;
          st_nxt = '0;
        end else begin
          st_nxt.partial_value   = acc;
          st_nxt.bytes_remaining = rem_dec;
        end
      end else begin
        // broken sequence, then the byte starts afresh
        e0_vld = 1'b1;
        e1_vld = sb_vld;
        st_nxt = '0;
        if (sb_open) begin
          st_nxt.partial_value   = sb_val;
          st_nxt.bytes_remaining = sb_extra;
          st_nxt.sequence_extra  = sb_extra;
        end
      end
    end else begin
      e1_vld = sb_vld;
      if (sb_open) begin
        st_nxt.partial_value   = sb_val;
        st_nxt.bytes_remaining = sb_extra;
        st_nxt.sequence_extra  = sb_extra;
      end
    end
    // nothing stays open past the end of the text
    if (last_in) begin
      st_nxt = '0;
    end
  end

  // Expand to code units; only a completed value can need a surrogate pair
  assign pair     = e0_vld && (form == FORM_UTF16) && (e0_cp >= SUPP_BASE);
  assign supp_off = e0_cp - SUPP_BASE;

  always_comb begin
    u0  = '0;
    u1  = '0;
    num = 2'd0;
    if (pair) begin
      u0.code_unit      = SURR_LO + {11'd0, supp_off[19:10]};
      u0.is_replacement = e0_rep;
      u1.code_unit      = LOW_SURR_BASE + (supp_off & TEN_BIT_MASK);
      u1.is_replacement = e0_rep;
      num               = 2'd2;
    end else if (e0_vld) begin
      u0.code_unit      = e0_cp;
      u0.is_replacement = e0_rep;
      u1.code_unit      = e1_cp;
      u1.is_replacement = e1_rep;
      num               = e1_vld ? 2'd2 : 2'd1;
    end else begin
      u0.code_unit      = e1_cp;
      u0.is_replacement = e1_rep;
      num               = {1'b0, e1_vld};
    end
    // mark the final result of this byte
    if (num == 2'd2) begin
      u1.run_last = 1'b1;
      u1.text_end = last_in;
    end else begin
      u0.run_last = 1'b1;
      u0.text_end = last_in;
    end
    emit.num   = num;
    emit.unit0 = u0;
    emit.unit1 = u1;
  end

endmodule

// File: rtl/utw_out_queue.sv
// Result queue: takes up to two results per cycle, delivers one per transfer
module utw_out_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_num,
  input  utw_pkg::utw_result_t push0,
  input  utw_pkg::utw_result_t push1,
  output logic                room,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                out_valid,
  input  logic                out_stall,
  output utw_pkg::utw_result_t head
);
  import utw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH-1);

  utw_result_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] wr_inc;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = cnt_r;
  // space for a worst-case byte, from registered state only
  assign room      = (cnt_r <= CNT_W'(DEPTH-2));

  // Pointer and count update
  always_comb begin
    wr_inc     = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (push_num == 2'd1) begin
      wr_ptr_nxt = wr_inc;
    end else if (push_num == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_inc);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push_num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_num == 2'd2) begin
      mem_r[wr_inc] <= push1;
    end
  end

endmodule
